// File: hdl/aht_pkg.sv
`timescale 1ns / 1ps

package aht_pkg;

  typedef logic [10:0] temp_t;
  typedef logic [6:0]  target_t;
  typedef logic [3:0]  delta_t;
  typedef logic [31:0] ms_t;
  typedef logic [15:0] lockout_t;

  localparam int TEMP_W = $bits(temp_t);

  typedef enum logic [1:0] {
    BTN_DELTA_DOWN  = 2'd0,
    BTN_DELTA_UP    = 2'd1,
    BTN_TARGET_DOWN = 2'd2,
    BTN_TARGET_UP   = 2'd3
  } button_t;

  typedef enum logic [1:0] {
    CFG_EDIT_ENABLE = 2'd0,
    CFG_START_TIME  = 2'd1,
    CFG_START_DELAY = 2'd2,
    CFG_LOCKOUT     = 2'd3
  } cfg_index_t;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_PRESS  = 1'b1;

  localparam target_t TARGET_MIN   = 7'd15;
  localparam target_t TARGET_MAX   = 7'd100;
  localparam target_t TARGET_RESET = 7'd45;
  localparam delta_t  DELTA_MIN    = 4'd1;
  localparam delta_t  DELTA_MAX    = 4'd10;
  localparam delta_t  DELTA_RESET  = 4'd2;

  localparam ms_t      START_DELAY_RESET = 32'd10000;
  localparam lockout_t LOCKOUT_RESET     = 16'd200;

  typedef struct packed {
    logic    req_type;
    button_t button;
    ms_t     now_ms;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
    temp_t average;
  } avg_stage_t;

  typedef struct packed {
    logic     edit_enable;
    ms_t      start_time_ms;
    ms_t      start_delay_ms;
    lockout_t lockout_ms;
  } cfg_regs_t;

  // The converter word is {hi, lo[7:3]}; a quarter of it keeps its top eleven bits.
  function automatic temp_t decode_sample(logic [7:0] hi, logic [7:0] lo, logic ok);
    temp_t t;
    t = ok ? {hi, lo[7:5]} : '0;
    return t;
  endfunction

endpackage

// File: hdl/aht_req_if.sv
`timescale 1ns / 1ps

interface aht_req_if;
  import aht_pkg::*;

  logic             valid;
  logic             ready;
  logic             req_type;
  logic [7:0]       raw_high;
  logic [7:0]       raw_low;
  logic             read_ok;
  button_t          button;
  ms_t              now_ms;

  modport source (output valid, req_type, raw_high, raw_low, read_ok, button, now_ms,
                  input ready);
  modport sink (input valid, req_type, raw_high, raw_low, read_ok, button, now_ms,
                output ready);
endinterface

// File: hdl/aht_rsp_if.sv
`timescale 1ns / 1ps

interface aht_rsp_if;
  import aht_pkg::*;

  logic    valid;
  logic    ready;
  temp_t   average_temp;
  logic    heater_on;
  target_t target_now;
  delta_t  delta_now;

  modport source (output valid, average_temp, heater_on, target_now, delta_now,
                  input ready);
  modport sink (input valid, average_temp, heater_on, target_now, delta_now,
                output ready);
endinterface

// File: hdl/aht_cfg_if.sv
`timescale 1ns / 1ps

interface aht_cfg_if;
  import aht_pkg::*;

  logic       valid;
  logic       ready;
  cfg_index_t addr;
  ms_t        data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// File: hdl/averaged_hysteresis_thermostat.sv
`timescale 1ns / 1ps

// Bang-bang thermostat driven by a moving average of AVG_DEPTH samples. One item
// (sample or button press) is taken every cycle while results are being taken; each
// item gives one result after the s1, s2 and output registers. The samples travel along
// a chain of AVG_DEPTH cells with a running sum beside it, the sum is divided by
// AVG_DEPTH through a registered reciprocal multiply, and the final stage holds the
// heater, setpoint and lockout state. All cells clear at reset, so no start-up pass
// is needed. Configuration is always ready and must be written while the block is idle.
module averaged_hysteresis_thermostat #(
  parameter int AVG_DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  aht_req_if.sink   req,
  aht_rsp_if.source rsp,
  aht_cfg_if.sink   cfg
);
  import aht_pkg::*;

  cfg_regs_t  cfg_regs;
  avg_stage_t stage;
  item_t      item;
  temp_t      sample;
  logic       advance;
  logic       accept;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.edit_enable    <= 1'b0;
      cfg_regs.start_time_ms  <= '0;
      cfg_regs.start_delay_ms <= START_DELAY_RESET;
      cfg_regs.lockout_ms     <= LOCKOUT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        CFG_EDIT_ENABLE: cfg_regs.edit_enable    <= cfg.data[0];
        CFG_START_TIME:  cfg_regs.start_time_ms  <= cfg.data;
        CFG_START_DELAY: cfg_regs.start_delay_ms <= cfg.data;
        CFG_LOCKOUT:     cfg_regs.lockout_ms     <= cfg.data[15:0];
      endcase
    end
  end

  assign req.ready     = advance;
  assign accept        = req.valid && advance;
  assign item.req_type = req.req_type;
  assign item.button   = req.button;
  assign item.now_ms   = req.now_ms;
  assign sample        = decode_sample(req.raw_high, req.raw_low, req.read_ok);

  aht_avg #(.AVG_DEPTH(AVG_DEPTH)) u_avg (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .accept  (accept),
    .item    (item),
    .sample  (sample),
    .stage   (stage)
  );

  aht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .stage    (stage),
    .advance  (advance),
    .rsp      (rsp)
  );

endmodule

// File: hdl/aht_cell.sv
`timescale 1ns / 1ps

module aht_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  aht_pkg::temp_t d,
  output aht_pkg::temp_t q
);
  import aht_pkg::*;

  temp_t value;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift) begin
      value <= d;
    end
  end

  assign q = value;

endmodule

// File: hdl/aht_avg.sv
`timescale 1ns / 1ps

module aht_avg #(
  parameter int AVG_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   accept,
  input  aht_pkg::item_t         item,
  input  aht_pkg::temp_t         sample,
  output aht_pkg::avg_stage_t    stage
);
  import aht_pkg::*;

  localparam int DEPTH_LOG = $clog2(AVG_DEPTH);
  localparam int SUM_W     = TEMP_W + DEPTH_LOG;
  localparam int SHIFT     = SUM_W + DEPTH_LOG;
  localparam int RECIP_W   = SUM_W + 2;
  localparam int PROD_W    = SUM_W + RECIP_W;
  // Rounded-up reciprocal: exact floor division for every sum below 2**SUM_W.
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  temp_t taps [AVG_DEPTH];
  logic  shift;

  assign shift = accept && (item.req_type == REQ_SAMPLE);

  genvar g;
  generate
    for (g = 0; g < AVG_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
        aht_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(sample), .q(taps[g]));
      end else begin : g_body
        aht_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(taps[g-1]), .q(taps[g]));
      end
    end
  endgenerate

  logic [SUM_W-1:0]  running_sum;
  logic [SUM_W-1:0]  running_sum_next;
  logic              s1_valid;
  item_t             s1_item;
  logic              s2_valid;
  item_t             s2_item;
  logic [PROD_W-1:0] product;

  // The last cell holds the sample that leaves the window.
  assign running_sum_next = running_sum - SUM_W'(taps[AVG_DEPTH-1]) + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (shift) begin
        running_sum <= running_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item <= item;
      s2_item <= s1_item;
      product <= PROD_W'(running_sum) * PROD_W'(RECIP);
    end
  end

  assign stage.valid   = s2_valid;
  assign stage.item    = s2_item;
  assign stage.average = product[SHIFT +: TEMP_W];

endmodule

// File: hdl/aht_ctrl.sv
`timescale 1ns / 1ps

module aht_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  aht_pkg::cfg_regs_t  cfg_regs,
  input  aht_pkg::avg_stage_t stage,
  output logic                advance,
  aht_rsp_if.source           rsp
);
  import aht_pkg::*;

  temp_t   last_average;
  logic    heater;
  target_t target_temp;
  delta_t  delta;
  ms_t     last_press_ms;

  temp_t   last_average_next;
  logic    heater_next;
  target_t target_temp_next;
  delta_t  delta_next;
  ms_t     last_press_ms_next;

  logic    out_valid;
  logic    proc;
  logic    proc_sample;
  logic    press_ok;
  ms_t     since_start;
  ms_t     since_press;
  logic [7:0]  upper_band;
  logic [11:0] lower_sum;

  assign advance     = !out_valid || rsp.ready;
  assign proc        = advance && stage.valid;
  assign proc_sample = proc && (stage.item.req_type == REQ_SAMPLE);

  assign since_start = stage.item.now_ms - cfg_regs.start_time_ms;
  assign since_press = stage.item.now_ms - last_press_ms;
  assign upper_band  = 8'(target_temp) + 8'(delta);
  assign lower_sum   = 12'(stage.average) + 12'(delta);
  assign press_ok    = cfg_regs.edit_enable && (since_press >= 32'(cfg_regs.lockout_ms));

  always_comb begin
    last_average_next  = last_average;
    heater_next        = heater;
    target_temp_next   = target_temp;
    delta_next         = delta;
    last_press_ms_next = last_press_ms;
    if (proc) begin
      if (stage.item.req_type == REQ_SAMPLE) begin
        last_average_next = stage.average;
        if (stage.average >= 11'(upper_band)) begin
          heater_next = 1'b0;
        end else if ((lower_sum < 12'(target_temp))
                     && (since_start > cfg_regs.start_delay_ms)) begin
          heater_next = 1'b1;
        end
      end else if (press_ok) begin
        unique case (stage.item.button)
          BTN_DELTA_DOWN:  if (delta > DELTA_MIN) delta_next = delta - 4'd1;
          BTN_DELTA_UP:    if (delta < DELTA_MAX) delta_next = delta + 4'd1;
          BTN_TARGET_DOWN: if (target_temp > TARGET_MIN) target_temp_next = target_temp - 7'd1;
          BTN_TARGET_UP:   if (target_temp < TARGET_MAX) target_temp_next = target_temp + 7'd1;
        endcase
        last_press_ms_next = stage.item.now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_average  <= '0;
      heater        <= 1'b0;
      target_temp   <= TARGET_RESET;
      delta         <= DELTA_RESET;
      last_press_ms <= '0;
      out_valid     <= 1'b0;
    end else begin
      last_average  <= last_average_next;
      heater        <= heater_next;
      target_temp   <= target_temp_next;
      delta         <= delta_next;
      last_press_ms <= last_press_ms_next;
      if (advance) begin
        out_valid <= stage.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      rsp.average_temp <= last_average_next;
      rsp.heater_on    <= heater_next;
      rsp.target_now   <= target_temp_next;
      rsp.delta_now    <= delta_next;
    end
  end

  assign rsp.valid = out_valid;

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    (target_temp >= TARGET_MIN) && (target_temp <= TARGET_MAX))
    else $error("target left its range");

  a_delta_range: assert property (@(posedge clk) disable iff (rst)
    (delta >= DELTA_MIN) && (delta <= DELTA_MAX))
    else $error("delta left its range");

  a_heater_on_sample: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (heater != $past(heater))) |-> $past(proc_sample))
    else $error("heater changed without a sample");

  a_setpoint_on_press: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && ((target_temp != $past(target_temp)) || (delta != $past(delta))))
      |-> $past(proc && press_ok && (stage.item.req_type == REQ_PRESS)))
    else $error("setpoint changed without an accepted press");

endmodule

// File: verif/aht_thermostat_checker.sv
`timescale 1ns / 1ps

module aht_thermostat_checker (
  input  logic clk,
  input  logic rst,
  aht_req_if   req,
  aht_rsp_if   rsp,
  aht_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding,
  output int   results_checked,
  output int   presses_taken,
  output int   heater_flips
);
  import aht_pkg::*;

  localparam int RING_LEN = 16;

  typedef struct packed {
    temp_t   average;
    logic    heater;
    target_t target;
    delta_t  delta;
  } reading_t;

  reading_t expected_readings[$];

  // Predicted thermostat state and register copies.
  temp_t       ring [RING_LEN];
  int unsigned ring_slot;
  logic [14:0] ring_total;
  temp_t       mean_deg;
  logic        heat;
  target_t     setpoint;
  delta_t      band;
  ms_t         last_taken_ms;
  logic        edit_on;
  ms_t         boot_ms;
  ms_t         warmup_ms;
  lockout_t    debounce_ms;

  function automatic reading_t thermostat_next(logic is_press, logic [7:0] hi,
                                               logic [7:0] lo, logic ok,
                                               button_t btn, ms_t now);
    temp_t    deg;
    logic     was_on;
    reading_t r;
    if (is_press == REQ_SAMPLE) begin
      // A quarter of the 13-bit converter word is the top eleven bits of {hi, lo}.
      deg = ok ? temp_t'({hi, lo} >> 5) : '0;
      ring_total = ring_total - ring[ring_slot] + deg;
      ring[ring_slot] = deg;
      ring_slot = (ring_slot + 1) % RING_LEN;
      mean_deg = temp_t'(ring_total / RING_LEN);
      was_on = heat;
      if (int'(mean_deg) >= int'(setpoint) + int'(band)) begin
        heat = 1'b0;
      end else if (int'(mean_deg) + int'(band) < int'(setpoint) &&
                   ms_t'(now - boot_ms) > warmup_ms) begin
        heat = 1'b1;
      end
      if (heat != was_on) heater_flips++;
    end else if (edit_on && ms_t'(now - last_taken_ms) >= ms_t'(debounce_ms)) begin
      case (btn)
        BTN_DELTA_DOWN:  if (band > DELTA_MIN) band--;
        BTN_DELTA_UP:    if (band < DELTA_MAX) band++;
        BTN_TARGET_DOWN: if (setpoint > TARGET_MIN) setpoint--;
        default:         if (setpoint < TARGET_MAX) setpoint++;
      endcase
      last_taken_ms = now;
      presses_taken++;
    end
    r.average = mean_deg;
    r.heater  = heat;
    r.target  = setpoint;
    r.delta   = band;
    return r;
  endfunction

  function automatic void note_mismatch(string what, reading_t want, reading_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%0t: %s: expected avg %0d heater %0b target %0d delta %0d, ",
             $realtime, what, want.average, want.heater, want.target, want.delta);
      $display("got avg %0d heater %0b target %0d delta %0d",
               got.average, got.heater, got.target, got.delta);
    end
  endfunction

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (rst) begin
      for (int i = 0; i < RING_LEN; i++) ring[i] = '0;
      ring_slot     = 0;
      ring_total    = '0;
      mean_deg      = '0;
      heat          = 1'b0;
      setpoint      = TARGET_RESET;
      band          = DELTA_RESET;
      last_taken_ms = '0;
      edit_on       = 1'b0;
      boot_ms       = '0;
      warmup_ms     = START_DELAY_RESET;
      debounce_ms   = LOCKOUT_RESET;
      expected_readings.delete();
      outstanding <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          CFG_EDIT_ENABLE: edit_on = cfg.data[0];
          CFG_START_TIME:  boot_ms = cfg.data;
          CFG_START_DELAY: warmup_ms = cfg.data;
          default:         debounce_ms = lockout_t'(cfg.data);
        endcase
      end
      // Results are compared before this edge's request is predicted: a result can
      // never belong to a request taken at the same edge.
      if (rsp.valid && rsp.ready) begin
        got.average = rsp.average_temp;
        got.heater  = rsp.heater_on;
        got.target  = rsp.target_now;
        got.delta   = rsp.delta_now;
        results_checked++;
        if (expected_readings.size() == 0) begin
          note_mismatch("Unexpected result", '0, got);
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) note_mismatch("Result mismatch", want, got);
        end
      end
      if (req.valid && req.ready) begin
        expected_readings.push_back(thermostat_next(req.req_type, req.raw_high,
                                                    req.raw_low, req.read_ok,
                                                    req.button, req.now_ms));
      end
      outstanding <= expected_readings.size();
    end
  end

endmodule

// File: verif/tb_averaged_hysteresis_thermostat.sv
`timescale 1ns / 1ps

module tb_averaged_hysteresis_thermostat;
  import aht_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic stall_rsp = 1'b0;
  logic steady = 1'b0;

  int   sent = 0;
  int   mismatches;
  int   outstanding;
  int   results_checked;
  int   presses_taken;
  int   heater_flips;

  ms_t  clock_ms = '0;
  int   room_deg = 40;
  logic warming = 1'b1;

  aht_req_if req_ch ();
  aht_rsp_if rsp_ch ();
  aht_cfg_if cfg_ch ();

  averaged_hysteresis_thermostat #(.AVG_DEPTH(16)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  aht_thermostat_checker thermo_check (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .results_checked(results_checked),
    .presses_taken(presses_taken),
    .heater_flips(heater_flips)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || stall_rsp) begin
      rsp_ch.ready <= 1'b0;
    end else if (steady) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= 15);
    end
  end

  // Long hold-off on the result side while requests keep coming, so the block backs up.
  initial begin
    wait (sent >= 120);
    @(posedge clk);
    stall_rsp <= 1'b1;
    repeat (300) @(posedge clk);
    stall_rsp <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic offer(input logic kind, input logic [7:0] hi, input logic [7:0] lo,
                       input logic ok, input button_t btn, input ms_t now);
    if (!steady && $urandom_range(99) < 15) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.raw_high <= hi;
    req_ch.raw_low  <= lo;
    req_ch.read_ok  <= ok;
    req_ch.button   <= btn;
    req_ch.now_ms   <= now;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  task automatic write_reg(input cfg_index_t idx, input ms_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic configure(input logic edit, input ms_t start, input ms_t delay,
                           input lockout_t lockout);
    write_reg(CFG_EDIT_ENABLE, ms_t'(edit));
    write_reg(CFG_START_TIME, start);
    write_reg(CFG_START_DELAY, delay);
    write_reg(CFG_LOCKOUT, ms_t'(lockout));
    cfg_ch.valid <= 1'b0;
  endtask

  // Lets the pipeline empty before the registers are touched.
  task automatic settle;
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (6) @(posedge clk);
  endtask

  // Samples follow a slowly sweeping room temperature so that the average crosses the
  // switching band repeatedly; presses lean up or down to drive the limits.
  task automatic random_run(input int count, input int press_pct, input int up_pct);
    logic [7:0] hi;
    logic [7:0] lo;
    logic       ok;
    button_t    btn;
    int         pick;
    int         deg;
    int         step;
    logic       go_up;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 3) clock_ms = $urandom();
      else if (pick < 8) clock_ms += $urandom_range(70000, 300);
      else clock_ms += $urandom_range(150);
      hi  = 8'($urandom());
      lo  = 8'($urandom());
      ok  = 1'($urandom());
      btn = button_t'($urandom_range(3));
      if ($urandom_range(99) < press_pct) begin
        go_up = ($urandom_range(99) < up_pct);
        if ($urandom_range(1)) btn = go_up ? BTN_TARGET_UP : BTN_TARGET_DOWN;
        else btn = go_up ? BTN_DELTA_UP : BTN_DELTA_DOWN;
        offer(REQ_PRESS, hi, lo, ok, btn, clock_ms);
      end else begin
        if ((warming && room_deg >= 130) || (!warming && room_deg <= 0) ||
            $urandom_range(99) < 2) begin
          warming = !warming;
        end
        step = $urandom_range(3);
        room_deg = warming ? room_deg + step : room_deg - step;
        if (room_deg < 0) room_deg = 0;
        pick = $urandom_range(99);
        if (pick >= 12) begin
          deg = room_deg + $urandom_range(4) - 2;
          if (deg < 0) deg = 0;
          hi = deg[10:3];
          lo = {deg[2:0], lo[4:0]};
          ok = 1'b1;
        end else if (pick >= 5) begin
          ok = 1'b1;
        end else begin
          ok = 1'b0;
        end
        offer(REQ_SAMPLE, hi, lo, ok, btn, clock_ms);
      end
    end
  endtask

  initial begin
    int waited;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_SAMPLE;
    req_ch.raw_high = '0;
    req_ch.raw_low  = '0;
    req_ch.read_ok  = 1'b0;
    req_ch.button   = BTN_DELTA_DOWN;
    req_ch.now_ms   = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.addr     = CFG_EDIT_ENABLE;
    cfg_ch.data     = '0;
    rsp_ch.ready    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: editing off, heater held back for the first ten seconds.
    offer(REQ_SAMPLE, 8'h00, 8'h00, 1'b1, BTN_TARGET_UP, 32'd1000);
    offer(REQ_SAMPLE, 8'hFF, 8'hFF, 1'b0, BTN_DELTA_UP, 32'd2000);
    offer(REQ_SAMPLE, 8'h0A, 8'hE0, 1'b1, BTN_DELTA_DOWN, 32'd3000);
    offer(REQ_PRESS, 8'hFF, 8'hFF, 1'b1, BTN_TARGET_UP, 32'd5000);
    offer(REQ_SAMPLE, 8'h05, 8'h60, 1'b1, BTN_TARGET_DOWN, 32'd10000);
    settle();

    // Start time just below the wrap, so the start delay is measured across it.
    configure(1'b1, 32'hFFFF_FFF0, 32'h20, 16'hFFFF);
    offer(REQ_SAMPLE, 8'h05, 8'h60, 1'b1, BTN_DELTA_DOWN, 32'h10);
    offer(REQ_SAMPLE, 8'h00, 8'h20, 1'b1, BTN_DELTA_DOWN, 32'h11);
    offer(REQ_SAMPLE, 8'hFF, 8'hFF, 1'b1, BTN_DELTA_DOWN, 32'h12);
    offer(REQ_PRESS, 8'h00, 8'h00, 1'b0, BTN_DELTA_DOWN, 32'd100);
    offer(REQ_PRESS, 8'h00, 8'h00, 1'b0, BTN_DELTA_DOWN, 32'd65535);
    offer(REQ_PRESS, 8'hFF, 8'hFF, 1'b1, BTN_DELTA_DOWN, 32'd131070);
    offer(REQ_PRESS, 8'h00, 8'h00, 1'b0, BTN_TARGET_DOWN, 32'd131071);
    offer(REQ_PRESS, 8'h00, 8'h00, 1'b0, BTN_TARGET_DOWN, 32'd5);
    offer(REQ_PRESS, 8'h00, 8'h00, 1'b0, BTN_TARGET_UP, 32'd65540);
    offer(REQ_PRESS, 8'h00, 8'h00, 1'b0, BTN_TARGET_UP, 32'd65541);
    settle();

    // No lockout and a start delay that can never be exceeded.
    configure(1'b1, 32'd0, 32'hFFFF_FFFF, 16'd0);
    offer(REQ_PRESS, 8'h00, 8'h00, 1'b0, BTN_DELTA_UP, 32'd0);
    offer(REQ_PRESS, 8'h00, 8'h00, 1'b0, BTN_DELTA_UP, 32'd0);
    offer(REQ_SAMPLE, 8'hFF, 8'h00, 1'b0, BTN_TARGET_UP, 32'hFFFF_FFFF);
    settle();

    configure(1'b1, 32'd0, 32'd0, 16'd0);
    random_run(280, 50, 95);
    settle();

    configure(1'b1, clock_ms, ms_t'($urandom_range(20000)), lockout_t'($urandom_range(60)));
    random_run(280, 50, 5);
    settle();

    configure(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    random_run(280, 20, 50);
    settle();

    steady <= 1'b1;
    configure(1'b1, $urandom(), $urandom(), lockout_t'($urandom_range(65535)));
    random_run(280, 20, 50);
    settle();
    steady <= 1'b0;

    clock_ms = 32'hFFFF_F000;
    configure(1'b1, clock_ms - 32'd5, 32'd0, 16'd1);
    random_run(280, 50, 5);
    settle();

    configure(1'b1, $urandom(), ms_t'($urandom_range(5000)), LOCKOUT_RESET);
    random_run(280, 20, 80);

    req_ch.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < 2000);
    repeat (8) @(posedge clk);

    $display("Sent %0d transactions and checked %0d results over nine register settings.",
             sent, results_checked);
    $display("%0d button presses took effect and the heater switched %0d times.",
             presses_taken, heater_flips);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
